// ===== hdl/lik_pkg.sv =====
`timescale 1ns / 1ps
package lik_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // datapath widths
  localparam int CW       = 34;  // cordic x/y
  localparam int AW       = 35;  // cordic angle accumulator, Q.30
  localparam int ANG_W    = 38;  // joint angle after mirroring and offsets
  localparam int SQ_STEPS = 31;  // one result bit per step
  localparam int SQ_W     = 62;  // remainder / root working width
  localparam int RW       = 31;  // root width
  localparam int VW       = 60;  // radicand width
  localparam int POS_W    = 20;

  localparam logic signed [AW-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [POS_W-1:0] POS_MAX = 20'sd524287;
  localparam logic signed [POS_W-1:0] POS_MIN = -20'sd524288;

  localparam logic [15:0] UPPER_LEN_RST   = 16'd1600;
  localparam logic [15:0] LOWER_LEN_RST   = 16'd1600;
  localparam logic [15:0] GEAR_RATIO_RST  = 16'd2330;

  typedef enum logic [2:0] {
    REG_UPPER_LEN   = 3'd0,
    REG_LOWER_LEN   = 3'd1,
    REG_RIGHT_SIDE  = 3'd2,
    REG_OFFSET_HIP  = 3'd3,
    REG_OFFSET_KNEE = 3'd4,
    REG_GEAR_RATIO  = 3'd5
  } lik_reg_e;

  typedef struct packed {
    logic [15:0]        upper_len;
    logic [15:0]        lower_len;
    logic               right_side;
    logic signed [15:0] offset_hip;
    logic signed [15:0] offset_knee;
    logic [15:0]        gear_ratio;
  } lik_cfg_t;

  // what travels alongside the square root
  typedef struct packed {
    logic signed [16:0] x;
    logic signed [15:0] z;
    logic signed [30:0] nn;
    logic signed [30:0] hn;
    logic               fail;
  } lik_pay_t;

  // atan(2^-i) in Q0.30
  function automatic logic [29:0] lik_atan(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/lik_front.sv =====
`timescale 1ns / 1ps
module lik_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [15:0]  x_i,
  input  logic signed [15:0]  z_i,
  input  lik_pkg::lik_cfg_t   cfg_i,
  output logic                valid_o,
  output logic [lik_pkg::VW-1:0] v_o,
  output lik_pkg::lik_pay_t   pay_o
);
  import lik_pkg::*;

  function automatic logic signed [30:0] trunc_sh(input logic signed [34:0] v,
                                                  input logic [2:0] s);
    logic [34:0] mg;
    logic [34:0] sh;
    logic signed [30:0] t;
    mg = v[34] ? 35'(-v) : 35'(v);
    sh = mg >> s;
    t  = $signed({1'b0, sh[29:0]});
    return v[34] ? -t : t;
  endfunction

  // stage 1: squares and products
  logic [4:0] vld_q;
  logic signed [16:0] xs_d, xs_q, x2_q, x3_q;
  logic signed [15:0] z1_q, z2_q, z3_q;
  logic signed [33:0] xsq, zsq;
  logic [31:0] xx_q, zz_q, uu_q, ll_q, ul_q;

  assign xs_d = cfg_i.right_side ? -17'(x_i) : 17'(x_i);
  assign xsq  = xs_d * xs_d;
  assign zsq  = 34'(z_i) * 34'(z_i);

  always_ff @(posedge clk_i) begin
    xs_q <= xs_d;
    z1_q <= z_i;
    xx_q <= xsq[31:0];
    zz_q <= zsq[31:0];
    uu_q <= cfg_i.upper_len * cfg_i.upper_len;
    ll_q <= cfg_i.lower_len * cfg_i.lower_len;
    ul_q <= cfg_i.upper_len * cfg_i.lower_len;
  end

  // stage 2: n, d, h
  logic signed [34:0] sum, n_d, h_d, n_q, h_q;
  logic [32:0] d_q;

  assign sum = $signed({3'b0, xx_q}) + $signed({3'b0, zz_q});
  assign n_d = sum - $signed({3'b0, uu_q}) - $signed({3'b0, ll_q});
  assign h_d = sum + $signed({3'b0, uu_q}) - $signed({3'b0, ll_q});

  always_ff @(posedge clk_i) begin
    x2_q <= xs_q;
    z2_q <= z1_q;
    n_q  <= n_d;
    h_q  <= h_d;
    d_q  <= {ul_q, 1'b0};
  end

  // stage 3: reach test and common scale
  logic [34:0] nmag, hmag, m1, m;
  logic [2:0]  s;
  logic [34:0] dsh;
  logic        fail3_q;
  logic signed [30:0] nn3_q, hn3_q;
  logic [29:0] dn3_q;

  assign nmag = n_q[34] ? 35'(-n_q) : 35'(n_q);
  assign hmag = h_q[34] ? 35'(-h_q) : 35'(h_q);
  assign m1   = (nmag > {2'b0, d_q}) ? nmag : {2'b0, d_q};
  assign m    = (hmag > m1) ? hmag : m1;

  always_comb begin
    if (m[34])      s = 3'd5;
    else if (m[33]) s = 3'd4;
    else if (m[32]) s = 3'd3;
    else if (m[31]) s = 3'd2;
    else if (m[30]) s = 3'd1;
    else            s = 3'd0;
  end

  assign dsh = {2'b0, d_q} >> s;

  always_ff @(posedge clk_i) begin
    x3_q    <= x2_q;
    z3_q    <= z2_q;
    fail3_q <= nmag > {2'b0, d_q};
    nn3_q   <= trunc_sh(n_q, s);
    hn3_q   <= trunc_sh(h_q, s);
    dn3_q   <= dsh[29:0];
  end

  // stage 4: squares of the scaled values
  lik_pay_t pay4_q, pay5_q;
  logic [29:0] nnmag;
  logic [59:0] dd_q, nq_q;
  logic [30:0] nneg;

  assign nneg  = 31'(-nn3_q);
  assign nnmag = nn3_q[30] ? nneg[29:0] : nn3_q[29:0];

  always_ff @(posedge clk_i) begin
    pay4_q.x    <= x3_q;
    pay4_q.z    <= z3_q;
    pay4_q.nn   <= nn3_q;
    pay4_q.hn   <= hn3_q;
    pay4_q.fail <= fail3_q;
    dd_q        <= dn3_q * dn3_q;
    nq_q        <= nnmag * nnmag;
  end

  // stage 5: radicand
  logic [VW-1:0] v_q;

  always_ff @(posedge clk_i) begin
    pay5_q <= pay4_q;
    v_q    <= pay4_q.fail ? '0 : dd_q - nq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign valid_o = vld_q[4];
  assign v_o     = v_q;
  assign pay_o   = pay5_q;

endmodule

// ===== hdl/lik_isqrt.sv =====
`timescale 1ns / 1ps
module lik_isqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [lik_pkg::VW-1:0]  v_i,
  input  lik_pkg::lik_pay_t       pay_i,
  output logic                    valid_o,
  output logic [lik_pkg::RW-1:0]  root_o,
  output lik_pkg::lik_pay_t       pay_o
);
  import lik_pkg::*;

  logic [SQ_W-1:0] rem_q  [SQ_STEPS];
  logic [SQ_W-1:0] root_q [SQ_STEPS];
  lik_pay_t        pay_q  [SQ_STEPS];
  logic            vld_q  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQ_W-1:0] rem_in, root_in, trial;
    lik_pay_t        pay_in;
    logic            vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = {{(SQ_W-VW){1'b0}}, v_i};
      assign root_in = '0;
      assign pay_in  = pay_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign pay_in  = pay_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = root_in + BIT;

    always_ff @(posedge clk_i) begin
      pay_q[k] <= pay_in;
      if (rem_in >= trial) begin
        rem_q[k]  <= rem_in - trial;
        root_q[k] <= (root_in >> 1) + BIT;
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[SQ_STEPS-1];
  assign root_o  = root_q[SQ_STEPS-1][RW-1:0];
  assign pay_o   = pay_q[SQ_STEPS-1];

endmodule

// ===== hdl/lik_cordic.sv =====
`timescale 1ns / 1ps
module lik_cordic #(
  parameter int unsigned STAGES = lik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic signed [lik_pkg::CW-1:0] x_i,
  input  logic signed [lik_pkg::CW-1:0] y_i,
  output logic signed [lik_pkg::AW-1:0] ang_o
);
  import lik_pkg::*;

  logic signed [CW-1:0] x_q [STAGES+1];
  logic signed [CW-1:0] y_q [STAGES+1];
  logic signed [AW-1:0] a_q [STAGES+1];

  // left half-plane vectors are turned by pi first
  always_ff @(posedge clk_i) begin
    if (x_i[CW-1]) begin
      x_q[0] <= -x_i;
      y_q[0] <= -y_i;
      a_q[0] <= y_i[CW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      x_q[0] <= x_i;
      y_q[0] <= y_i;
      a_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic signed [AW-1:0] ATN = $signed({{(AW-30){1'b0}}, lik_atan(5'(k))});
    logic signed [CW-1:0] dx, dy;

    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (y_q[k] == '0) begin
        x_q[k+1] <= x_q[k];
        y_q[k+1] <= y_q[k];
        a_q[k+1] <= a_q[k];
      end else if (!y_q[k][CW-1]) begin
        x_q[k+1] <= x_q[k] + dx;
        y_q[k+1] <= y_q[k] - dy;
        a_q[k+1] <= a_q[k] + ATN;
      end else begin
        x_q[k+1] <= x_q[k] - dx;
        y_q[k+1] <= y_q[k] + dy;
        a_q[k+1] <= a_q[k] - ATN;
      end
    end
  end

  assign ang_o = a_q[STAGES];

endmodule

// ===== hdl/lik_motor.sv =====
`timescale 1ns / 1ps
module lik_motor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic                             fail_i,
  input  logic signed [lik_pkg::AW-1:0]    a_xz_i,
  input  logic signed [lik_pkg::AW-1:0]    a_k_i,
  input  logic signed [lik_pkg::AW-1:0]    a_h_i,
  input  lik_pkg::lik_cfg_t                cfg_i,
  output logic                             done_o,
  output logic signed [lik_pkg::POS_W-1:0] hip_o,
  output logic signed [lik_pkg::POS_W-1:0] knee_o,
  output logic                             oor_o
);
  import lik_pkg::*;

  localparam int LO_W = 19;
  localparam int HI_W = ANG_W - LO_W;
  localparam int PW   = ANG_W + 18;

  // round half up at bit 26, then saturate
  function automatic logic signed [POS_W-1:0] to_pos(input logic signed [HI_W+16:0] hi,
                                                     input logic [LO_W+15:0] lo);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] r;
    p = ($signed({{(PW-HI_W-17){hi[HI_W+16]}}, hi}) <<< LO_W)
        + $signed({{(PW-LO_W-16){1'b0}}, lo})
        + (PW'(1) <<< 25);
    r = p >>> 26;
    if (r > PW'(POS_MAX))      return POS_MAX;
    else if (r < PW'(POS_MIN)) return POS_MIN;
    else                       return r[POS_W-1:0];
  endfunction

  logic signed [ANG_W-1:0] th, hip_d, knee_d, hip1_q, knee1_q, offh, offk;
  logic signed [ANG_W-1:0] axz, ak, ah, pi_w;
  logic [2:0] vld_q;
  logic f1_q, f2_q, f3_q;

  assign axz  = ANG_W'(a_xz_i);
  assign ak   = ANG_W'(a_k_i);
  assign ah   = ANG_W'(a_h_i);
  assign pi_w = ANG_W'(PI_Q30);
  assign offh = ANG_W'(cfg_i.offset_hip) <<< 17;
  assign offk = ANG_W'(cfg_i.offset_knee) <<< 17;
  assign th   = axz - ah;

  always_comb begin
    if (cfg_i.right_side) begin
      hip_d  = th - offh;
      knee_d = ak - pi_w - offk;
    end else begin
      hip_d  = -th - offh;
      knee_d = pi_w - ak - offk;
    end
  end

  always_ff @(posedge clk_i) begin
    hip1_q  <= hip_d;
    knee1_q <= knee_d;
    f1_q    <= fail_i;
  end

  // split products keep each multiplier near 19 by 17
  logic [LO_W+15:0]         hlo_q, klo_q;
  logic signed [HI_W+16:0]  hhi_q, khi_q;
  logic signed [16:0]       g_s;

  assign g_s = $signed({1'b0, cfg_i.gear_ratio});

  always_ff @(posedge clk_i) begin
    hlo_q <= hip1_q[LO_W-1:0] * cfg_i.gear_ratio;
    klo_q <= knee1_q[LO_W-1:0] * cfg_i.gear_ratio;
    hhi_q <= $signed(hip1_q[ANG_W-1:LO_W]) * g_s;
    khi_q <= $signed(knee1_q[ANG_W-1:LO_W]) * g_s;
    f2_q  <= f1_q;
  end

  logic signed [POS_W-1:0] hip_q, knee_q;

  always_ff @(posedge clk_i) begin
    hip_q  <= to_pos(hhi_q, hlo_q);
    knee_q <= to_pos(khi_q, klo_q);
    f3_q   <= f2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign done_o = vld_q[2];
  assign hip_o  = hip_q;
  assign knee_o = knee_q;
  assign oor_o  = f3_q;

endmodule

// ===== hdl/two_link_leg_inverse_kinematics.sv =====
`timescale 1ns / 1ps
// Two-link leg inverse kinematics. A foot target (foot_x_i, foot_z_i) is
// taken at every clock edge where start is high; busy is always low, so a
// new target may follow in each cycle. Each target gives one result,
// shown for exactly one cycle with done_o high, after the pipeline:
// squaring and scaling, a square root that resolves one bit per pipeline
// stage (31), one pre-turn plus one stage per CORDIC iteration for the
// three atan2 lanes that run side by side, and the mirroring, offsets and
// the gear multiply. The receiver cannot hold off a result; it must take
// it in that cycle. Registers are written through cfg_we_i with no wait
// and should change only while no target is in flight.
module two_link_leg_inverse_kinematics #(
  parameter int unsigned CORDIC_STAGES = lik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [15:0]               foot_x_i,
  input  logic signed [15:0]               foot_z_i,
  output logic                             done_o,
  output logic signed [lik_pkg::POS_W-1:0] motor_pos_hip_o,
  output logic signed [lik_pkg::POS_W-1:0] motor_pos_knee_o,
  output logic                             out_of_reach_o,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [15:0]                      cfg_data_i
);
  import lik_pkg::*;

  localparam int LAT = 40 + CORDIC_STAGES;

  lik_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_len   <= UPPER_LEN_RST;
      cfg_q.lower_len   <= LOWER_LEN_RST;
      cfg_q.right_side  <= 1'b0;
      cfg_q.offset_hip  <= '0;
      cfg_q.offset_knee <= '0;
      cfg_q.gear_ratio  <= GEAR_RATIO_RST;
    end else if (cfg_we_i) begin
      case (lik_reg_e'(cfg_idx_i))
        REG_UPPER_LEN:   cfg_q.upper_len   <= cfg_data_i;
        REG_LOWER_LEN:   cfg_q.lower_len   <= cfg_data_i;
        REG_RIGHT_SIDE:  cfg_q.right_side  <= cfg_data_i[0];
        REG_OFFSET_HIP:  cfg_q.offset_hip  <= $signed(cfg_data_i);
        REG_OFFSET_KNEE: cfg_q.offset_knee <= $signed(cfg_data_i);
        REG_GEAR_RATIO:  cfg_q.gear_ratio  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic          fr_valid;
  logic [VW-1:0] fr_v;
  lik_pay_t      fr_pay;

  lik_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .x_i     (foot_x_i),
    .z_i     (foot_z_i),
    .cfg_i   (cfg_q),
    .valid_o (fr_valid),
    .v_o     (fr_v),
    .pay_o   (fr_pay)
  );

  logic          sq_valid;
  logic [RW-1:0] sq_root;
  lik_pay_t      sq_pay;

  lik_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .v_i     (fr_v),
    .pay_i   (fr_pay),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .pay_o   (sq_pay)
  );

  logic signed [CW-1:0] yr, lx, lz, lnn, lhn;
  logic signed [AW-1:0] a_xz, a_k, a_h;

  assign yr  = $signed({{(CW-RW){1'b0}}, sq_root});
  assign lx  = CW'(sq_pay.x);
  assign lz  = CW'(sq_pay.z);
  assign lnn = CW'(sq_pay.nn);
  assign lhn = CW'(sq_pay.hn);

  lik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_xz (
    .clk_i (clk_i), .x_i (lx), .y_i (lz), .ang_o (a_xz)
  );

  lik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_knee (
    .clk_i (clk_i), .x_i (lnn), .y_i (yr), .ang_o (a_k)
  );

  lik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_hip (
    .clk_i (clk_i), .x_i (lhn), .y_i (yr), .ang_o (a_h)
  );

  // valid and reach flag ride alongside the cordic lanes
  logic [CORDIC_STAGES:0] dv_q, df_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[CORDIC_STAGES-1:0], sq_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    df_q <= {df_q[CORDIC_STAGES-1:0], sq_pay.fail};
  end

  lik_motor u_motor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_q[CORDIC_STAGES]),
    .fail_i  (df_q[CORDIC_STAGES]),
    .a_xz_i  (a_xz),
    .a_k_i   (a_k),
    .a_h_i   (a_h),
    .cfg_i   (cfg_q),
    .done_o  (done_o),
    .hip_o   (motor_pos_hip_o),
    .knee_o  (motor_pos_knee_o),
    .oor_o   (out_of_reach_o)
  );

  a_request_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT done_o)
    else $error("request did not complete at the pipeline latency");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(start && !busy, LAT) |-> !done_o)
    else $error("result without a matching request");

  a_zero_gear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(cfg_q.gear_ratio, 2) == '0 |->
      motor_pos_hip_o == '0 && motor_pos_knee_o == '0)
    else $error("zero gear ratio gave a nonzero motor position");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import lik_pkg::*;

  localparam int STAGES     = 16;
  localparam int LATENCY    = 40 + STAGES;
  localparam int STALL_MAX  = 2000;
  localparam longint PI_FIX = 64'sd3373259426;

  typedef struct {
    logic signed [POS_W-1:0] hip;
    logic signed [POS_W-1:0] knee;
    logic                    reach_fail;
  } joint_pos_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] foot_x_i = '0;
  logic signed [15:0] foot_z_i = '0;
  logic done_o;
  logic signed [POS_W-1:0] motor_pos_hip_o;
  logic signed [POS_W-1:0] motor_pos_knee_o;
  logic out_of_reach_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  lik_cfg_t leg_cfg;
  joint_pos_t pending_pos[$];
  int errors = 0;
  int stall_cnt = 0;
  bit idle_en = 1'b1;

  const longint arctan_q30[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  two_link_leg_inverse_kinematics dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint acc, dx, dy;
    acc = 0;
    if (x < 0) begin
      acc = (y >= 0) ? PI_FIX : -PI_FIX;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (y == 0) break;
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        acc += arctan_q30[i];
      end else begin
        x -= dx;
        y += dy;
        acc -= arctan_q30[i];
      end
    end
    return acc;
  endfunction

  function automatic longint cut_down(longint v, int s);
    return (v >= 0) ? (v >>> s) : -((-v) >>> s);
  endfunction

  function automatic logic signed [POS_W-1:0] motor_of(longint ang);
    longint r;
    r = (ang * longint'(leg_cfg.gear_ratio) + (64'sd1 <<< 25)) >>> 26;
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[POS_W-1:0];
  endfunction

  function automatic joint_pos_t leg_angles(logic signed [15:0] fx, logic signed [15:0] fz);
    joint_pos_t res;
    longint x, z, lu, ll, n, d, h, m, nn, dn, hn, yr, th_hip, th_knee, hip, knee;
    int s;
    x = fx;
    z = fz;
    lu = leg_cfg.upper_len;
    ll = leg_cfg.lower_len;
    s = 0;
    if (leg_cfg.right_side) x = -x;
    n = x * x + z * z - lu * lu - ll * ll;
    d = 2 * lu * ll;
    h = x * x + z * z + lu * lu - ll * ll;
    res.reach_fail = ((n < 0 ? -n : n) > d);
    m = n < 0 ? -n : n;
    if (d > m) m = d;
    if ((h < 0 ? -h : h) > m) m = h < 0 ? -h : h;
    while ((m >>> s) >= (64'sd1 <<< 30)) s++;
    nn = cut_down(n, s);
    dn = cut_down(d, s);
    hn = cut_down(h, s);
    yr = res.reach_fail ? 0 : longint'(int_sqrt(longint'(dn * dn - nn * nn)));
    th_knee = vector_angle(nn, yr);
    th_hip = vector_angle(x, z) - vector_angle(hn, yr);
    if (leg_cfg.right_side) begin
      hip = th_hip;
      knee = th_knee - PI_FIX;
    end else begin
      hip = -th_hip;
      knee = PI_FIX - th_knee;
    end
    hip -= longint'(leg_cfg.offset_hip) * 131072;
    knee -= longint'(leg_cfg.offset_knee) * 131072;
    res.hip = motor_of(hip);
    res.knee = motor_of(knee);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // one request; called at a falling edge, returns at a falling edge
  task automatic send_foot(logic signed [15:0] fx, logic signed [15:0] fz);
    while (idle_en && $urandom_range(99) < 22) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    foot_x_i = fx;
    foot_z_i = fz;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_pos.push_back(leg_angles(fx, fz));
    @(negedge clk_i);
  endtask

  task automatic write_reg(lik_reg_e idx, logic [15:0] val);
    start = 1'b0;
    while (pending_pos.size() != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      REG_UPPER_LEN:   leg_cfg.upper_len = val;
      REG_LOWER_LEN:   leg_cfg.lower_len = val;
      REG_RIGHT_SIDE:  leg_cfg.right_side = val[0];
      REG_OFFSET_HIP:  leg_cfg.offset_hip = val;
      REG_OFFSET_KNEE: leg_cfg.offset_knee = val;
      default:         leg_cfg.gear_ratio = val;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_leg(logic [15:0] lu, logic [15:0] ll, logic side,
                         logic [15:0] oh, logic [15:0] ok, logic [15:0] gr);
    write_reg(REG_UPPER_LEN, lu);
    write_reg(REG_LOWER_LEN, ll);
    write_reg(REG_RIGHT_SIDE, {15'd0, side});
    write_reg(REG_OFFSET_HIP, oh);
    write_reg(REG_OFFSET_KNEE, ok);
    write_reg(REG_GEAR_RATIO, gr);
  endtask

  task automatic test_field_extremes;
    send_foot(16'sh7fff, 16'sh7fff);
    send_foot(-16'sh8000, -16'sh8000);
    send_foot(-16'sh8000, 16'sh7fff);
    send_foot(16'sh7fff, -16'sh8000);
    send_foot(0, 0);
    send_foot(0, -16'sd2000);
    send_foot(16'sd1000, -16'sd1500);
    send_foot(-16'sd3200, 0);
    send_foot(0, 16'sd3200);
  endtask

  task automatic test_sides;
    set_leg(16'd1600, 16'd1600, 1'b1, 16'h7fff, 16'h8000, 16'd2330);
    send_foot(16'sd1000, -16'sd1500);
    send_foot(-16'sd800, -16'sd2500);
    send_foot(0, 0);
    set_leg(16'd1600, 16'd1600, 1'b0, 16'h8000, 16'h7fff, 16'hffff);
    send_foot(16'sd1000, -16'sd1500);
    send_foot(16'sh7fff, 16'sh7fff);
  endtask

  task automatic test_link_corners;
    // zero link length and zero gear ratio
    set_leg(16'd0, 16'd1600, 1'b0, 16'd0, 16'd0, 16'd0);
    send_foot(0, -16'sd1600);
    send_foot(16'sd1000, 16'sd200);
    set_leg(16'd1, 16'hffff, 1'b1, 16'd100, 16'hff00, 16'd256);
    send_foot(-16'sh8000, -16'sh8000);
    send_foot(16'sd100, -16'sd9);
    set_leg(16'hffff, 16'hffff, 1'b0, 16'd0, 16'd0, 16'd2330);
    send_foot(16'sh7fff, -16'sh8000);
    send_foot(0, 0);
  endtask

  task automatic test_random;
    int span;
    for (int ph = 0; ph < 8; ph++) begin
      start = 1'b0;
      set_leg(16'($urandom_range(ph == 7 ? 65535 : 4000, 1)),
              16'($urandom_range(ph == 6 ? 65535 : 4000, 1)), 1'($urandom_range(1)),
              16'($urandom), 16'($urandom),
              ph == 5 ? 16'hffff : 16'($urandom_range(65535)));
      idle_en = (ph != 3);
      span = leg_cfg.upper_len + leg_cfg.lower_len;
      if (span > 32767) span = 32767;
      for (int k = 0; k < 250; k++) begin
        if ($urandom_range(99) < 75)
          send_foot(16'(int'($urandom_range(2 * span)) - span),
                    16'(int'($urandom_range(2 * span)) - span));
        else
          send_foot(16'($urandom), 16'($urandom));
      end
    end
    idle_en = 1'b1;
    start = 1'b0;
  endtask

  always @(posedge clk_i) begin
    joint_pos_t e;
    if (rst_ni && done_o) begin
      if (pending_pos.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
      end else begin
        e = pending_pos.pop_front();
        if (motor_pos_hip_o !== e.hip) report_mismatch("hip", motor_pos_hip_o, e.hip);
        if (motor_pos_knee_o !== e.knee) report_mismatch("knee", motor_pos_knee_o, e.knee);
        if (out_of_reach_o !== e.reach_fail)
          report_mismatch("out_of_reach", out_of_reach_o, e.reach_fail);
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i || !rst_ni) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_MAX) begin
      $display("two_link_leg_inverse_kinematics verification failed");
      $finish;
    end
  end

  initial begin
    leg_cfg = '{upper_len: UPPER_LEN_RST, lower_len: LOWER_LEN_RST, right_side: 1'b0,
                offset_hip: '0, offset_knee: '0, gear_ratio: GEAR_RATIO_RST};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_field_extremes();
    test_sides();
    test_link_corners();
    test_random();
    while (pending_pos.size() != 0) @(negedge clk_i);
    repeat (2 * LATENCY) @(negedge clk_i);
    if (errors == 0 && pending_pos.size() == 0)
      $display("two_link_leg_inverse_kinematics verification clean");
    else
      $display("two_link_leg_inverse_kinematics verification failed");
    $finish;
  end

endmodule
